// ----- design/sssf_pkg.sv -----
// Shared types, request codes and segment tables for the seven-segment
// serial formatter. No dependencies.
package sssf_pkg;

  localparam int FRAME_W = 24;
  localparam int CNT_W   = 5;

  localparam logic [2:0] REQ_INT  = 3'd0;
  localparam logic [2:0] REQ_REAL = 3'd1;
  localparam logic [2:0] REQ_TEXT = 3'd2;
  localparam logic [2:0] REQ_RUN  = 3'd3;
  localparam logic [2:0] REQ_CAL  = 3'd4;

  localparam logic [9:0] INT_MAX  = 10'd99;
  localparam logic [9:0] REAL_MAX = 10'd999;

  localparam logic [7:0] SEG_R = 8'hC8;
  localparam logic [7:0] SEG_U = 8'hC1;
  localparam logic [7:0] SEG_N = 8'h88;
  localparam logic [7:0] SEG_C = 8'hC7;
  localparam logic [7:0] SEG_A = 8'h88;
  localparam logic [7:0] SEG_L = 8'hC6;

  localparam logic [CNT_W-1:0] BITS_TWO   = 5'd16;
  localparam logic [CNT_W-1:0] BITS_THREE = 5'd24;

  // Encoded request handed to the serializer; bytes left-aligned, MSB first.
  typedef struct packed {
    logic               ok;
    logic [FRAME_W-1:0] frame;
    logic [CNT_W-1:0]   nbits;
  } frame_t;

  function automatic logic [7:0] digit_std(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'hC0;
      4'd1: s = 8'hF9;
      4'd2: s = 8'hA4;
      4'd3: s = 8'hB0;
      4'd4: s = 8'h99;
      4'd5: s = 8'h92;
      4'd6: s = 8'h82;
      4'd7: s = 8'hF8;
      4'd8: s = 8'h80;
      4'd9: s = 8'h90;
      default: s = 8'hFF;
    endcase
    return s;
  endfunction

  // Alternate glyphs for 3, 5 and 9.
  function automatic logic [7:0] digit_alt(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd3: s = 8'hA8;
      4'd5: s = 8'h8A;
      4'd9: s = 8'h88;
      default: s = digit_std(d);
    endcase
    return s;
  endfunction

  // Standard glyph with the decimal point lit (bit 7 low).
  function automatic logic [7:0] digit_dot(input logic [3:0] d);
    return digit_std(d) & 8'h7F;
  endfunction

endpackage

// ----- design/sssf_req_if.sv -----
// Request and result channel interfaces for the seven-segment formatter.
// No dependencies.
interface sssf_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [9:0] number_value;
  logic [7:0] text_first;
  logic [7:0] text_second;

  modport source (output valid, req_type, number_value, text_first, text_second,
                  input ready);
  modport sink   (input valid, req_type, number_value, text_first, text_second,
                  output ready);
endinterface

interface sssf_res_if;
  logic valid;
  logic ready;
  logic shift_bit;
  logic is_latch;
  logic last;

  modport source (output valid, shift_bit, is_latch, last, input ready);
  modport sink   (input valid, shift_bit, is_latch, last, output ready);
endinterface

// ----- design/sssf_encoder.sv -----
// Turns one registered request into a left-aligned segment frame.
// Depends on sssf_pkg.
module sssf_encoder
  import sssf_pkg::*;
(
  input  logic [2:0] req_type,
  input  logic [9:0] number_value,
  input  logic [7:0] text_first,
  input  logic [7:0] text_second,
  output frame_t     enc
);

  logic [9:0]  n;
  logic [17:0] p10;
  logic [15:0] p100;
  logic [6:0]  q10;
  logic [3:0]  q100;
  logic [3:0]  ones;
  logic [3:0]  tens;

  always_comb begin
    if (req_type == REQ_INT) begin
      n = (number_value > INT_MAX) ? INT_MAX : number_value;
    end else begin
      n = (number_value > REAL_MAX) ? REAL_MAX : number_value;
    end
    // n/10 and n/100 by reciprocal multiply, exact for n <= 999
    p10  = 18'(n) * 18'd205;
    p100 = 16'(n) * 16'd41;
    q10  = p10[17:11];
    q100 = p100[15:12];
    ones = 4'(n - 10'(q10) * 10'd10);
    tens = 4'(q10 - 7'(q100) * 7'd10);
  end

  always_comb begin
    enc = '0;
    unique case (req_type)
      REQ_INT: begin
        enc.ok    = 1'b1;
        enc.frame = {digit_alt(ones), digit_alt(q10[3:0]), 8'h00};
        enc.nbits = BITS_TWO;
      end
      REQ_REAL: begin
        enc.ok    = 1'b1;
        enc.frame = {digit_std(ones), digit_dot(tens), digit_std(q100)};
        enc.nbits = BITS_THREE;
      end
      REQ_TEXT: begin
        enc.ok    = 1'b1;
        enc.frame = {text_second, text_first, 8'h00};
        enc.nbits = BITS_TWO;
      end
      REQ_RUN: begin
        enc.ok    = 1'b1;
        enc.frame = {SEG_R, SEG_U, SEG_N};
        enc.nbits = BITS_THREE;
      end
      REQ_CAL: begin
        enc.ok    = 1'b1;
        enc.frame = {SEG_C, SEG_A, SEG_L};
        enc.nbits = BITS_THREE;
      end
      default: enc = '0;
    endcase
  end

endmodule

// ----- design/sssf_serializer.sv -----
// Shifts a segment frame out one bit per result, then a latch result.
// Depends on sssf_pkg and sssf_res_if.
module sssf_serializer
  import sssf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  frame_t            enc,
  output logic              can_load,
  sssf_res_if.source        res
);

  logic [FRAME_W-1:0] frame;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               res_valid;
  logic               out_free;

  assign out_free  = !res_valid || res.ready;
  // next frame may load in the cycle its predecessor's latch goes out
  assign can_load  = !busy || (out_free && cnt == '0);
  assign res.valid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_free) begin
        res_valid <= busy;
        if (busy) begin
          if (cnt != '0) begin
            res.shift_bit <= frame[FRAME_W-1];
            res.is_latch  <= 1'b0;
            res.last      <= 1'b0;
            frame         <= {frame[FRAME_W-2:0], 1'b0};
            cnt           <= cnt - 1'b1;
          end else begin
            res.shift_bit <= 1'b0;
            res.is_latch  <= 1'b1;
            res.last      <= 1'b1;
          end
        end
      end
      if (load && can_load) begin
        frame <= enc.frame;
        cnt   <= enc.nbits;
        busy  <= 1'b1;
      end else if (out_free && busy && cnt == '0) begin
        busy  <= 1'b0;
      end
    end
  end

endmodule

// ----- design/seven_segment_serial_formatter_unit.sv -----
// Seven-segment serial formatter: request register, encoder, serializer.
// Depends on sssf_pkg, sssf_req_if, sssf_encoder and sssf_serializer.
//
// Usage: a display request (type, number, two text bytes) enters on req.
// Each request yields a stream on res: one result per shift clock pulse,
// segment bytes MSB first, then one latch result flagged is_latch and last.
// Two-byte modes (integer, text) give 17 results, three-byte modes (real,
// RUN, CAL) give 25. Unknown types are taken and give no results.
// Throughput: one result per cycle from the single output register while
// res does not stall; the next request waits in the request register and
// its first bit follows the previous latch with no gap.
// Reset clears the request register, the serializer and the output valid;
// a stream in flight is dropped. When res stalls, the output register holds
// its result and shifting pauses; req.ready drops once the request register
// is full and the serializer cannot load it.
module seven_segment_serial_formatter_unit
  import sssf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  sssf_req_if.sink   req,
  sssf_res_if.source res
);

  logic       pend_valid;
  logic [2:0] pend_type;
  logic [9:0] pend_num;
  logic [7:0] pend_first;
  logic [7:0] pend_second;
  frame_t     enc;
  logic       can_load;
  logic       take;

  assign take      = pend_valid && (!enc.ok || can_load);
  assign req.ready = !pend_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        pend_valid  <= 1'b1;
        pend_type   <= req.req_type;
        pend_num    <= req.number_value;
        pend_first  <= req.text_first;
        pend_second <= req.text_second;
      end else if (take) begin
        pend_valid <= 1'b0;
      end
    end
  end

  sssf_encoder u_enc (
    .req_type     (pend_type),
    .number_value (pend_num),
    .text_first   (pend_first),
    .text_second  (pend_second),
    .enc          (enc)
  );

  sssf_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .load     (pend_valid && enc.ok),
    .enc      (enc),
    .can_load (can_load),
    .res      (res)
  );

endmodule

// ----- design/sssf_checker.sv -----
// Port-level checks for the seven-segment formatter, bound to the top level.
// Depends on seven_segment_serial_formatter_unit.
module sssf_checker (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input logic res_shift_bit,
  input logic res_is_latch,
  input logic res_last
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid &&
      $stable({res_shift_bit, res_is_latch, res_last}))
    else $error("result changed while stalled");

  a_latch: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_last |-> res_is_latch && !res_shift_bit)
    else $error("last result is not a clean latch");

  a_rst: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // a taken latch is never directly followed by another latch result
  a_gap: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res_last |=> !(res_valid && res_is_latch))
    else $error("latch without shift bits");

endmodule

bind seven_segment_serial_formatter_unit sssf_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_shift_bit (res.shift_bit),
  .res_is_latch  (res.is_latch),
  .res_last      (res.last)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for seven_segment_serial_formatter_unit: directed table then
// random display requests, checked bit by bit against a local encoder model.
// Depends on sssf_pkg, sssf_req_if, sssf_res_if and the formatter RTL.
module testbench
  import sssf_pkg::*;
();

  localparam logic [2:0] REQ_RSVD5 = 3'd5;
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  localparam int RAND_REQS    = 375;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 30;

  typedef struct packed {
    logic shift_bit;
    logic is_latch;
    logic last;
  } pulse_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  num;
    logic [7:0]  t_first;
    logic [7:0]  t_second;
    logic        typed;
    logic [1:0]  nbytes;
    logic [23:0] bytes;
  } disp_row_t;

  logic clk;
  logic rst;

  sssf_req_if req ();
  sssf_res_if res ();

  seven_segment_serial_formatter_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  pulse_t    pulse_q[$];
  disp_row_t dir_tab[$];
  int        err_cnt   = 0;
  int        cycle_cnt = 0;
  bit        quiet     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Segment glyph, active low; alt selects the alternate 3, 5 and 9.
  function automatic logic [7:0] glyph(input int d, input bit alt);
    logic [7:0] g;
    case (d)
      0: g = 8'hC0;
      1: g = 8'hF9;
      2: g = 8'hA4;
      3: g = alt ? 8'hA8 : 8'hB0;
      4: g = 8'h99;
      5: g = alt ? 8'h8A : 8'h92;
      6: g = 8'h82;
      7: g = 8'hF8;
      8: g = 8'h80;
      default: g = alt ? 8'h88 : 8'h90;
    endcase
    return g;
  endfunction

  // Bytes left-aligned in shift order.
  function automatic void encode_display(input logic [2:0] kind, input logic [9:0] num,
                                         input logic [7:0] tf, input logic [7:0] ts,
                                         output int nb, output logic [23:0] bytes);
    int v;
    v     = int'(num);
    nb    = 0;
    bytes = '0;
    case (kind)
      REQ_INT: begin
        if (v > int'(INT_MAX)) v = int'(INT_MAX);
        bytes = {glyph(v % 10, 1'b1), glyph(v / 10, 1'b1), 8'h00};
        nb    = 2;
      end
      REQ_REAL: begin
        if (v > int'(REAL_MAX)) v = int'(REAL_MAX);
        bytes = {glyph(v % 10, 1'b0), glyph((v / 10) % 10, 1'b0) & 8'h7F,
                 glyph(v / 100, 1'b0)};
        nb    = 3;
      end
      REQ_TEXT: begin
        bytes = {ts, tf, 8'h00};
        nb    = 2;
      end
      REQ_RUN: begin
        bytes = {8'hC8, 8'hC1, 8'h88};
        nb    = 3;
      end
      REQ_CAL: begin
        bytes = {8'hC7, 8'h88, 8'hC6};
        nb    = 3;
      end
      default: nb = 0;
    endcase
  endfunction

  function automatic void push_stream(input int nb, input logic [23:0] bytes);
    pulse_t p;
    for (int i = 0; i < nb * 8; i++) begin
      p = {bytes[23-i], 1'b0, 1'b0};
      pulse_q.push_back(p);
    end
    if (nb > 0) begin
      p = {1'b0, 1'b1, 1'b1};
      pulse_q.push_back(p);
    end
  endfunction

  // Mostly short gaps, a few long ones; none while quiet.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void add_row(input logic [2:0] kind, input logic [9:0] num,
                                  input logic [7:0] tf, input logic [7:0] ts,
                                  input logic typed, input int nb,
                                  input logic [23:0] bytes);
    disp_row_t row;
    row = {kind, num, tf, ts, typed, 2'(nb), bytes};
    dir_tab.push_back(row);
  endfunction

  task automatic send_display(input logic [2:0] kind, input logic [9:0] num,
                              input logic [7:0] tf, input logic [7:0] ts,
                              input logic typed, input int tnb, input logic [23:0] tbytes);
    int          gap;
    int          nb;
    logic [23:0] bytes;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid        = 1'b1;
    req.req_type     = kind;
    req.number_value = num;
    req.text_first   = tf;
    req.text_second  = ts;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (typed) begin
      nb    = tnb;
      bytes = tbytes;
    end else begin
      encode_display(kind, num, tf, ts, nb, bytes);
    end
    push_stream(nb, bytes);
    @(negedge clk);
  endtask

  // Result sink with random back-pressure.
  initial begin
    int stall_left;
    stall_left = 0;
    res.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res.ready  = 1'b0;
        stall_left = stall_left - 1;
      end else begin
        res.ready = 1'b1;
        if ($urandom_range(0, 99) < 15) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    pulse_t want;
    if (!rst && res.valid && res.ready) begin
      if (pulse_q.size() == 0) begin
        $display("%0t: unexpected result shift_bit=%0b is_latch=%0b last=%0b",
                 $time, res.shift_bit, res.is_latch, res.last);
        err_cnt++;
      end else begin
        want = pulse_q.pop_front();
        if (res.shift_bit !== want.shift_bit || res.is_latch !== want.is_latch ||
            res.last !== want.last) begin
          $display("%0t: mismatch exp shift_bit=%0b is_latch=%0b last=%0b got %0b %0b %0b",
                   $time, want.shift_bit, want.is_latch, want.last,
                   res.shift_bit, res.is_latch, res.last);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int          n;
    logic [2:0]  kind;
    logic [9:0]  num;
    disp_row_t   row;
    rst              = 1'b1;
    req.valid        = 1'b0;
    req.req_type     = REQ_INT;
    req.number_value = '0;
    req.text_first   = '0;
    req.text_second  = '0;

    //      kind       num      first  second typed nb bytes
    add_row(REQ_INT,   10'd0,    8'hFF, 8'hFF, 1'b1, 2, 24'hC0C000);
    add_row(REQ_INT,   10'd99,   8'h00, 8'h00, 1'b1, 2, 24'h888800);
    add_row(REQ_INT,   10'd100,  8'h00, 8'hFF, 1'b1, 2, 24'h888800);
    add_row(REQ_INT,   10'd1023, 8'hFF, 8'h00, 1'b1, 2, 24'h888800);
    add_row(REQ_INT,   10'd35,   8'h5A, 8'hA5, 1'b0, 0, 24'h0);
    add_row(REQ_INT,   10'd42,   8'h00, 8'h00, 1'b0, 0, 24'h0);
    add_row(REQ_INT,   10'd9,    8'h00, 8'h00, 1'b0, 0, 24'h0);
    add_row(REQ_REAL,  10'd0,    8'hFF, 8'hFF, 1'b1, 3, 24'hC040C0);
    add_row(REQ_REAL,  10'd999,  8'h00, 8'h00, 1'b1, 3, 24'h901090);
    add_row(REQ_REAL,  10'd1000, 8'h00, 8'h00, 1'b1, 3, 24'h901090);
    add_row(REQ_REAL,  10'd1023, 8'hFF, 8'hFF, 1'b1, 3, 24'h901090);
    add_row(REQ_REAL,  10'd123,  8'h00, 8'h00, 1'b0, 0, 24'h0);
    add_row(REQ_REAL,  10'd507,  8'h00, 8'h00, 1'b0, 0, 24'h0);
    add_row(REQ_REAL,  10'd90,   8'h00, 8'h00, 1'b0, 0, 24'h0);
    add_row(REQ_TEXT,  10'd0,    8'h00, 8'hFF, 1'b1, 2, 24'hFF0000);
    add_row(REQ_TEXT,  10'd1023, 8'hFF, 8'h00, 1'b1, 2, 24'h00FF00);
    add_row(REQ_TEXT,  10'd512,  8'hA5, 8'h5A, 1'b0, 0, 24'h0);
    add_row(REQ_RUN,   10'd0,    8'h00, 8'h00, 1'b1, 3, 24'hC8C188);
    add_row(REQ_RUN,   10'd1023, 8'hFF, 8'hFF, 1'b1, 3, 24'hC8C188);
    add_row(REQ_CAL,   10'd0,    8'h00, 8'h00, 1'b1, 3, 24'hC788C6);
    add_row(REQ_RSVD5, 10'd55,   8'h12, 8'h34, 1'b1, 0, 24'h0);
    add_row(REQ_RSVD6, 10'd1023, 8'hFF, 8'hFF, 1'b1, 0, 24'h0);
    add_row(REQ_RSVD7, 10'd0,    8'h00, 8'h00, 1'b1, 0, 24'h0);
    add_row(REQ_CAL,   10'd777,  8'h3C, 8'hC3, 1'b1, 3, 24'hC788C6);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      send_display(row.kind, row.num, row.t_first, row.t_second, row.typed,
                   int'(row.nbytes), row.bytes);
    end

    n = 0;
    while (n < RAND_REQS) begin
      // A window with no idling on either side.
      quiet = (n >= 200 && n < 280);
      if ($urandom_range(0, 99) < 88) begin
        kind = 3'($urandom_range(REQ_INT, REQ_CAL));
        n++;
      end else begin
        kind = 3'($urandom_range(REQ_RSVD5, REQ_RSVD7));
      end
      case ($urandom_range(0, 3))
        0, 1: num = (kind == REQ_INT) ? 10'($urandom_range(0, 99)) :
                                       10'($urandom_range(0, 999));
        2: num = 10'($urandom_range(0, 1023));
        default: num = (kind == REQ_INT) ? 10'($urandom_range(90, 110)) :
                                          10'($urandom_range(990, 1023));
      endcase
      send_display(kind, num, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'b0, 0, 24'h0);
    end

    req.valid = 1'b0;
    quiet     = 1'b1;
    while (pulse_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/sssf_pkg.sv
design/sssf_req_if.sv
design/sssf_encoder.sv
design/sssf_serializer.sv
design/seven_segment_serial_formatter_unit.sv
design/sssf_checker.sv
tb/testbench.sv
